// ===== src/rmq_pkg.sv =====
// rmq_pkg: shared types, constants and per-stage step functions for
// rotation_matrix_to_quaternion. No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

	localparam int SqSteps    = 3;
	localparam int SqStages   = 5;
	localparam int DivSteps   = 3;
	localparam int DivStages  = 5;

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	// square root stage word
	typedef struct packed {
		logic [1:0]        br;
		logic              degen;
		logic [2:0][16:0]  d;
		logic [29:0]       rad;
		logic [14:0]       root;
		logic [16:0]       rem;
	} sq_t;

	// divider stage word
	typedef struct packed {
		logic [1:0]        br;
		logic              degen;
		logic [14:0]       h;
		logic [2:0]        neg;
		logic [2:0]        ovf;
		logic [2:0][14:0]  rem;
		logic [2:0][14:0]  nlow;
		logic [2:0][14:0]  q;
	} dv_t;

	function automatic sq_t sq_iter(sq_t a);
		sq_t b;
		logic [18:0] t;
		logic [16:0] trial;
		b = a;
		for (int i = 0; i < SqSteps; i++) begin
			t = {b.rem, b.rad[29:28]};
			trial = {b.root, 2'b01};
			if (t >= {2'b00, trial}) begin
				b.rem = 17'(t - {2'b00, trial});
				b.root = {b.root[13:0], 1'b1};
			end else begin
				b.rem = t[16:0];
				b.root = {b.root[13:0], 1'b0};
			end
			b.rad = {b.rad[27:0], 2'b00};
		end
		return b;
	endfunction

	function automatic dv_t div_iter(dv_t a);
		dv_t b;
		logic [15:0] t;
		b = a;
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < DivSteps; i++) begin
				t = {b.rem[j], b.nlow[j][14]};
				if (t >= {1'b0, b.h}) begin
					b.rem[j] = 15'(t - {1'b0, b.h});
					b.q[j] = {b.q[j][13:0], 1'b1};
				end else begin
					b.rem[j] = t[14:0];
					b.q[j] = {b.q[j][13:0], 1'b0};
				end
				b.nlow[j] = {b.nlow[j][13:0], 1'b0};
			end
		end
		return b;
	endfunction

	function automatic logic [15:0] fin(logic neg, logic ovf, logic [14:0] q);
		logic [15:0] r;
		if (ovf) begin
			r = neg ? 16'h8000 : 16'h7fff;
		end else begin
			r = neg ? 16'(-{1'b0, q}) : {1'b0, q};
		end
		return r;
	endfunction

endpackage

// ===== src/rotation_matrix_to_quaternion.sv =====
// rotation_matrix_to_quaternion: Shepperd matrix to quaternion, Q1.14, pipelined.
// Depends on rmq_pkg.
//
// channel  dir  handshake            words
// input    in   in_valid/in_stall    e00..e22
// output   out  out_valid/out_stall  qx qy qz qw branch_taken degenerate
//
// One word per cycle unless the output stalls. Stages: select stage, five root stages
// (three root bits each), divisor prep, five divide stages (three quotient
// bits each), output register. Async reset clears valid bits only.
// A stall on a valid output word freezes the whole pipe; in_stall follows it.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] e00,
	input  logic signed [15:0] e01,
	input  logic signed [15:0] e02,
	input  logic signed [15:0] e10,
	input  logic signed [15:0] e11,
	input  logic signed [15:0] e12,
	input  logic signed [15:0] e20,
	input  logic signed [15:0] e21,
	input  logic signed [15:0] e22,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] qx,
	output logic signed [15:0] qy,
	output logic signed [15:0] qz,
	output logic signed [15:0] qw,
	output logic [1:0]         branch_taken,
	output logic               degenerate
);
	import rmq_pkg::*;

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// select stage
	logic signed [17:0] trace;
	logic signed [18:0] a_c;
	logic signed [16:0] d0_c, d1_c, d2_c;
	logic [1:0]         br_c;
	logic signed [16:0] s01, s02, s12, x21, x02, x10;

	always_comb begin
		trace = 18'(e00) + 18'(e11) + 18'(e22);
		s01 = 17'(e01) + 17'(e10);
		s02 = 17'(e02) + 17'(e20);
		s12 = 17'(e12) + 17'(e21);
		x21 = 17'(e21) - 17'(e12);
		x02 = 17'(e02) - 17'(e20);
		x10 = 17'(e10) - 17'(e01);
		if (trace > 0) begin
			br_c = BR_TRACE;
			a_c = 19'sd16384 + 19'(trace);
			d0_c = x21; d1_c = x02; d2_c = x10;
		end else if (e00 > e11 && e00 > e22) begin
			br_c = BR_X;
			a_c = 19'sd16384 + 19'(e00) - 19'(e11) - 19'(e22);
			d0_c = x21; d1_c = s01; d2_c = s02;
		end else if (e11 > e22) begin
			br_c = BR_Y;
			a_c = 19'sd16384 + 19'(e11) - 19'(e00) - 19'(e22);
			d0_c = x02; d1_c = s01; d2_c = s12;
		end else begin
			br_c = BR_Z;
			a_c = 19'sd16384 + 19'(e22) - 19'(e00) - 19'(e11);
			d0_c = x10; d1_c = s02; d2_c = s12;
		end
	end

	sq_t  sq_s [SqStages+1];
	logic sq_v_s [SqStages+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			sq_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].br <= br_c;
			sq_s[0].degen <= !(a_c > 0);
			sq_s[0].d <= {d2_c, d1_c, d0_c};
			sq_s[0].rad <= (a_c > 0) ? {1'b0, a_c[16:0], 12'b0} : 30'd0;
			sq_s[0].root <= '0;
			sq_s[0].rem <= '0;
		end
	end

	for (genvar k = 1; k <= SqStages; k++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k] <= sq_v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k] <= sq_iter(sq_s[k-1]);
			end
		end
	end

	// divisor prep
	dv_t  dv_s [DivStages+1];
	logic dv_v_s [DivStages+1];
	dv_t  prep_c;

	always_comb begin
		logic signed [16:0] dj;
		logic [16:0]        mag;
		logic [28:0]        n;
		prep_c = '0;
		prep_c.br = sq_s[SqStages].br;
		prep_c.degen = sq_s[SqStages].degen;
		prep_c.h = sq_s[SqStages].root;
		for (int j = 0; j < 3; j++) begin
			dj = sq_s[SqStages].d[j];
			mag = dj[16] ? 17'(-dj) : 17'(dj);
			n = {mag[16:0], 12'b0} + 29'(sq_s[SqStages].root[14:1]);
			prep_c.neg[j] = dj[16];
			prep_c.ovf[j] = {1'b0, n[28:15]} >= sq_s[SqStages].root;
			prep_c.rem[j] = {1'b0, n[28:15]};
			prep_c.nlow[j] = n[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= sq_v_s[SqStages];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= prep_c;
		end
	end

	for (genvar k = 1; k <= DivStages; k++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k] <= div_iter(dv_s[k-1]);
			end
		end
	end

	// output stage
	dv_t         last;
	logic [15:0] c0, c1, c2, hv;
	logic [15:0] x_c, y_c, z_c, w_c;
	logic        v_s13;
	logic [15:0] qx_s13, qy_s13, qz_s13, qw_s13;
	logic [1:0]  br_s13;
	logic        degen_s13;

	always_comb begin
		last = dv_s[DivStages];
		c0 = fin(last.neg[0], last.ovf[0], last.q[0]);
		c1 = fin(last.neg[1], last.ovf[1], last.q[1]);
		c2 = fin(last.neg[2], last.ovf[2], last.q[2]);
		hv = {1'b0, last.h};
		case (last.br)
			BR_TRACE: begin x_c = c0; y_c = c1; z_c = c2; w_c = hv; end
			BR_X:     begin x_c = hv; y_c = c1; z_c = c2; w_c = c0; end
			BR_Y:     begin x_c = c1; y_c = hv; z_c = c2; w_c = c0; end
			default:  begin x_c = c1; y_c = c2; z_c = hv; w_c = c0; end
		endcase
		if (last.degen) begin
			x_c = '0; y_c = '0; z_c = '0; w_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s13 <= dv_v_s[DivStages];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s13 <= x_c;
			qy_s13 <= y_c;
			qz_s13 <= z_c;
			qw_s13 <= w_c;
			br_s13 <= last.br;
			degen_s13 <= last.degen;
		end
	end

	assign out_valid = v_s13;
	assign qx = qx_s13;
	assign qy = qy_s13;
	assign qz = qz_s13;
	assign qw = qw_s13;
	assign branch_taken = br_s13;
	assign degenerate = degen_s13;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (qx == 0 && qy == 0 && qz == 0 && qw == 0))
		else $error("degenerate word with nonzero components");

	a_trace_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_v_s[0] && sq_s[0].br == BR_TRACE) |-> !sq_s[0].degen)
		else $error("trace branch flagged degenerate");

	a_root_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !degenerate && branch_taken == BR_X) |-> (qx >= 16'sd64))
		else $error("root component below minimum");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(dv_v_s[DivStages]) && $stable(sq_v_s[0])))
		else $error("pipe moved during stall");

endmodule
